// File: hw/rtl/gbc_pkg.sv
// -----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants of the gyro bias calibration and median filter.
// -----------------------------------------------------------------------------
package gbc_pkg;

	localparam int RATE_W = 28;
	localparam int RAW_W  = 16;
	localparam int MULT_W = 28;
	localparam int PROD_W = RAW_W + MULT_W;
	localparam int CFG_IDX_W = 3;

	localparam int WINDOW_DEPTH_DEF   = 5;
	localparam int STABLE_SAMPLES_DEF = 100;
	localparam int WARMUP_SAMPLES_DEF = 5;

	localparam logic signed [RATE_W-1:0] Q_ONE       = 28'sd1048576;
	localparam logic signed [RATE_W-1:0] Q_MONE      = -28'sd1048576;
	localparam logic signed [RATE_W:0]   SPREAD_MAX  = 29'sd52429;
	localparam logic signed [RATE_W-1:0] STILL_CAL   = 28'sd20972;
	localparam logic signed [RATE_W-1:0] STILL_UNCAL = 28'sd104858;
	localparam logic signed [RATE_W-1:0] RATE_MAX    = 28'sh7FFFFFF;
	localparam logic signed [RATE_W-1:0] RATE_MIN    = 28'sh8000000;
	localparam logic signed [PROD_W-1:0] ROUND_HALF  = 44'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE    = 3'd0,
		REG_PRELOAD  = 3'd1,
		REG_PRESET_X = 3'd2,
		REG_PRESET_Y = 3'd3,
		REG_PRESET_Z = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic restart;
		logic upd;
		logic set_bias;
		logic win_we;
		logic preload;
	} lane_ctrl_t;

	typedef struct packed {
		logic motion;
		logic spread;
	} lane_stat_t;

	function automatic logic signed [MULT_W-1:0] scale_mult(input logic [1:0] sel);
		logic signed [MULT_W-1:0] m;
		case (sel)
			2'd0:    m = 28'sd10494585;
			2'd1:    m = 28'sd20989170;
			default: m = 28'sd83956679;
		endcase
		return m;
	endfunction

endpackage

// File: hw/rtl/gbc_if.sv
// -----------------------------------------------------------------------------
// gbc_in_if / gbc_out_if
// Valid/ready channels for raw samples and filtered results.
// -----------------------------------------------------------------------------
interface gbc_in_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  raw_x;
	logic signed [15:0]  raw_y;
	logic signed [15:0]  raw_z;

	modport source (output valid, raw_x, raw_y, raw_z, input ready);
	modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface gbc_out_if;
	logic                valid;
	logic                ready;
	logic signed [27:0]  rate_x;
	logic signed [27:0]  rate_y;
	logic signed [27:0]  rate_z;
	logic                is_calibrated;
	logic                held_still;
	logic signed [27:0]  bias_out_x;
	logic signed [27:0]  bias_out_y;
	logic signed [27:0]  bias_out_z;

	modport source (output valid, rate_x, rate_y, rate_z, is_calibrated, held_still,
		bias_out_x, bias_out_y, bias_out_z, input ready);
	modport sink   (input valid, rate_x, rate_y, rate_z, is_calibrated, held_still,
		bias_out_x, bias_out_y, bias_out_z, output ready);
endinterface

// File: hw/rtl/gyro_bias_calibrate_median_filter.sv
// -----------------------------------------------------------------------------
// gyro_bias_calibrate_median_filter
// Gyro rate scaling, stationary bias calibration and median denoise, top level.
// -----------------------------------------------------------------------------
// Usage: raw x/y/z samples arrive as beats on the sample channel; one result
// beat per sample leaves on the result channel with the filtered rates in
// Q7.20, the calibrated and held-still flags and the current bias.
// Three axis lanes run side by side; the top merges their motion and spread
// flags into the calibration decision; the still clamp acts on the medians.
// Result valid rises after the sample beat is accepted and has passed the
// registers in order: multiply, bias subtract with calibration update and
// window write, then median and clamp into the output register. One sample
// is taken every cycle unless a stalled receiver has filled the stages.
// Configuration is a write port (cfg_we, cfg_idx, cfg_data); write only while
// the block holds no sample. Writing 1 to REG_PRELOAD loads the preset bias.
// At reset the bias is zero, collection starts over, warm-up restarts and the
// median window is empty. When the receiver stalls, the result is held and
// the stages behind it keep filling until full, then ready drops.
// -----------------------------------------------------------------------------
module gyro_bias_calibrate_median_filter #(
	parameter int WINDOW_DEPTH   = gbc_pkg::WINDOW_DEPTH_DEF,
	parameter int STABLE_SAMPLES = gbc_pkg::STABLE_SAMPLES_DEF,
	parameter int WARMUP_SAMPLES = gbc_pkg::WARMUP_SAMPLES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	gbc_in_if.sink                                sample,
	gbc_out_if.source                             result,
	input  logic                                  cfg_we,
	input  logic [gbc_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [gbc_pkg::RATE_W-1:0]            cfg_data
);
	import gbc_pkg::*;

	localparam int IW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW  = $clog2(WINDOW_DEPTH + 1);
	localparam int SCW = $clog2(STABLE_SAMPLES + 1);
	localparam int WWR = $clog2(WARMUP_SAMPLES + 1);
	localparam int WW  = (WWR > 0) ? WWR : 1;

	logic [1:0]               range_q;
	logic signed [RATE_W-1:0] preset_q [3];
	logic                     cal_q;
	logic [SCW-1:0]           stable_q;
	logic [WW-1:0]            warm_q;
	logic [IW-1:0]            idx_q;
	logic [FW-1:0]            fill_q;

	logic v_s1, v_s2, ov_q;
	logic adv_o, adv2, adv1, ld_s1, ld_s2, ld_o;
	logic filt_s2;

	lane_ctrl_t ctrl;
	lane_stat_t stat [3];
	logic signed [RAW_W-1:0]  raw [3];
	logic signed [RATE_W-1:0] lv [3];
	logic signed [RATE_W-1:0] lb [3];
	logic signed [RATE_W-1:0] lm [3];
	logic                     motion_any, spread_any, warm_done;
	logic signed [RATE_W-1:0] lim;
	logic                     still;

	assign adv_o = !ov_q || result.ready;
	assign adv2  = !v_s2 || adv_o;
	assign adv1  = !v_s1 || adv2;
	assign ld_o  = v_s2 && adv_o;
	assign ld_s2 = v_s1 && adv2;
	assign ld_s1 = sample.valid && adv1;
	assign sample.ready = adv1;

	assign raw[0] = sample.raw_x;
	assign raw[1] = sample.raw_y;
	assign raw[2] = sample.raw_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (adv1)  v_s1 <= sample.valid;
			if (adv2)  v_s2 <= v_s1;
			if (adv_o) ov_q <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q     <= '0;
			preset_q[0] <= '0;
			preset_q[1] <= '0;
			preset_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RANGE:    range_q     <= cfg_data[1:0];
				REG_PRELOAD:  ;
				REG_PRESET_X: preset_q[0] <= cfg_data;
				REG_PRESET_Y: preset_q[1] <= cfg_data;
				REG_PRESET_Z: preset_q[2] <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign motion_any = stat[0].motion || stat[1].motion || stat[2].motion;
	assign spread_any = stat[0].spread || stat[1].spread || stat[2].spread;
	assign warm_done  = (32'(warm_q) >= WARMUP_SAMPLES);

	always_comb begin
		ctrl = '0;
		ctrl.preload = cfg_we && (cfg_idx == REG_PRELOAD) && cfg_data[0];
		ctrl.win_we  = warm_done;
		if (!cal_q) begin
			if (motion_any) begin
				ctrl.restart = 1'b1;
			end else if (32'(stable_q) < STABLE_SAMPLES) begin
				ctrl.restart = spread_any;
				ctrl.upd     = !spread_any;
			end else begin
				ctrl.set_bias = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			stable_q <= '0;
			warm_q   <= '0;
			idx_q    <= '0;
			fill_q   <= '0;
			filt_s2  <= 1'b0;
		end else if (ctrl.preload) begin
			cal_q <= 1'b1;
		end else if (ld_s2) begin
			if (ctrl.restart) begin
				stable_q <= '0;
			end else if (ctrl.upd) begin
				stable_q <= stable_q + SCW'(1);
			end else if (ctrl.set_bias) begin
				cal_q <= 1'b1;
			end
			filt_s2 <= warm_done;
			if (warm_done) begin
				idx_q <= (32'(idx_q) == WINDOW_DEPTH - 1) ? '0 : idx_q + IW'(1);
				if (32'(fill_q) < WINDOW_DEPTH) begin
					fill_q <= fill_q + FW'(1);
				end
			end else begin
				warm_q <= warm_q + WW'(1);
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lane
		gbc_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.raw       (raw[a]),
			.range_sel (range_q),
			.ld_s1     (ld_s1),
			.ld_s2     (ld_s2),
			.ctrl      (ctrl),
			.win_idx   (idx_q),
			.fill      (fill_q),
			.preset    (preset_q[a]),
			.stat      (stat[a]),
			.v_s2      (lv[a]),
			.bias      (lb[a]),
			.med       (lm[a])
		);
	end

	always_comb begin
		lim   = cal_q ? STILL_CAL : STILL_UNCAL;
		still = filt_s2;
		for (int a = 0; a < 3; a++) begin
			if (!(lm[a] < lim && lm[a] > -lim)) begin
				still = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_o) begin
			result.rate_x        <= still ? '0 : (filt_s2 ? lm[0] : lv[0]);
			result.rate_y        <= still ? '0 : (filt_s2 ? lm[1] : lv[1]);
			result.rate_z        <= still ? '0 : (filt_s2 ? lm[2] : lv[2]);
			result.is_calibrated <= cal_q;
			result.held_still    <= still;
			result.bias_out_x    <= lb[0];
			result.bias_out_y    <= lb[1];
			result.bias_out_z    <= lb[2];
		end
	end

	assign result.valid = ov_q;

	assert property (@(posedge clk) disable iff (!arst_n) !$fell(cal_q))
		else $error("calibrated flag dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(stable_q) <= STABLE_SAMPLES && 32'(fill_q) <= WINDOW_DEPTH)
		else $error("counter out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_o |-> !ld_s2 ##1 v_s2)
		else $error("stage two overwritten while stalled");

endmodule

// File: hw/rtl/gbc_lane.sv
// -----------------------------------------------------------------------------
// gbc_lane
// One axis: scale, bias subtract, min/max tracking, window and lower median.
// -----------------------------------------------------------------------------
module gbc_lane #(
	parameter int WINDOW_DEPTH = gbc_pkg::WINDOW_DEPTH_DEF,
	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
	localparam int FW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [gbc_pkg::RAW_W-1:0]     raw,
	input  logic [1:0]                           range_sel,
	input  logic                                 ld_s1,
	input  logic                                 ld_s2,
	input  gbc_pkg::lane_ctrl_t                  ctrl,
	input  logic [IW-1:0]                        win_idx,
	input  logic [FW-1:0]                        fill,
	input  logic signed [gbc_pkg::RATE_W-1:0]    preset,
	output gbc_pkg::lane_stat_t                  stat,
	output logic signed [gbc_pkg::RATE_W-1:0]    v_s2,
	output logic signed [gbc_pkg::RATE_W-1:0]    bias,
	output logic signed [gbc_pkg::RATE_W-1:0]    med
);
	import gbc_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [RATE_W-1:0] scaled;
	logic signed [RATE_W:0]   diff;
	logic signed [RATE_W-1:0] v;
	logic signed [RATE_W-1:0] nmin;
	logic signed [RATE_W-1:0] nmax;
	logic signed [RATE_W:0]   sum_mm;
	logic signed [RATE_W-1:0] bias_q;
	logic signed [RATE_W-1:0] min_q;
	logic signed [RATE_W-1:0] max_q;
	logic signed [RATE_W-1:0] win_q [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]  pick;
	logic [FW-1:0]            rank [WINDOW_DEPTH];
	logic [FW-1:0]            mid;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			prod_s1 <= PROD_W'(raw) * PROD_W'(scale_mult(range_sel));
		end
	end

	always_comb begin
		rnd    = prod_s1 + ROUND_HALF;
		scaled = rnd[PROD_W-1 -: RATE_W];
		diff   = {scaled[RATE_W-1], scaled} - {bias_q[RATE_W-1], bias_q};
		if (diff[RATE_W] != diff[RATE_W-1]) begin
			v = diff[RATE_W] ? RATE_MIN : RATE_MAX;
		end else begin
			v = diff[RATE_W-1:0];
		end
		nmin = (v < min_q) ? v : min_q;
		nmax = (v > max_q) ? v : max_q;
		stat.motion = (v >= Q_ONE) || (v <= Q_MONE);
		stat.spread = (({nmax[RATE_W-1], nmax} - {nmin[RATE_W-1], nmin}) > SPREAD_MAX);
		sum_mm = {max_q[RATE_W-1], max_q} + {min_q[RATE_W-1], min_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			min_q  <= Q_ONE;
			max_q  <= Q_MONE;
		end else if (ctrl.preload) begin
			bias_q <= preset;
		end else if (ld_s2) begin
			if (ctrl.restart) begin
				bias_q <= '0;
				min_q  <= Q_ONE;
				max_q  <= Q_MONE;
			end else if (ctrl.upd) begin
				min_q <= nmin;
				max_q <= nmax;
			end else if (ctrl.set_bias) begin
				bias_q <= sum_mm[RATE_W:1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			v_s2 <= v;
			if (ctrl.win_we) begin
				win_q[win_idx] <= v;
			end
		end
	end

	always_comb begin
		mid = FW'((fill - FW'(1)) >> 1);
		med = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				if (j != i && FW'(j) < fill &&
						((win_q[j] < win_q[i]) || (win_q[j] == win_q[i] && j < i))) begin
					rank[i] = rank[i] + FW'(1);
				end
			end
			pick[i] = (FW'(i) < fill) && (rank[i] == mid);
			if (pick[i]) begin
				med = med | win_q[i];
			end
		end
	end

	assign bias = bias_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ld_s2 && ctrl.restart |=> min_q == Q_ONE && max_q == Q_MONE && bias_q == '0)
		else $error("restart did not reset collection");
	assert property (@(posedge clk) disable iff (!arst_n)
		ld_s2 && ctrl.upd |=> min_q <= max_q)
		else $error("min above max after update");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill != '0 |-> $onehot(pick))
		else $error("median select not unique");

endmodule

// File: verif/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gyro bias calibration and median filter: drives
// raw sample beats with random idling on both channels, predicts result beats
// from its model of scaling, calibration, warm-up and median clamp (a fixed
// beat for typed rows) and compares each one field by field in arrival order.
// -----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gbc_pkg::*;

	typedef struct packed {
		logic signed [27:0] rx, ry, rz;
		logic               cal, still;
		logic signed [27:0] bx, by, bz;
	} gyro_res_t;

	typedef struct packed {
		logic signed [15:0] x, y, z;
		logic               typed;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [RATE_W-1:0] cfg_data = '0;

	gbc_in_if  sample();
	gbc_out_if result();

	gyro_bias_calibrate_median_filter dut (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [1:0]         m_range;
	logic signed [27:0] m_preset[3];
	logic signed [27:0] m_bias[3], m_min[3], m_max[3];
	int                 m_stable, m_warm, m_fill, m_idx;
	logic               m_cal;
	logic signed [27:0] m_win[3][5];

	gyro_res_t rate_expect_q[$];
	int  errors = 0;
	int  idle_free = 0;
	int  quiet_cycles = 0;

	function automatic void restart_collect();
		m_stable = 0;
		for (int a = 0; a < 3; a++) begin
			m_bias[a] = '0;
			m_min[a] = Q_ONE;
			m_max[a] = Q_MONE;
		end
	endfunction

	function automatic logic signed [27:0] sat_rate(input longint v);
		if (v > longint'(RATE_MAX))
			return RATE_MAX;
		if (v < longint'(RATE_MIN))
			return RATE_MIN;
		return v[27:0];
	endfunction

	function automatic logic signed [27:0] axis_median(input int a, input int n);
		logic signed [27:0] t[5];
		logic signed [27:0] x;
		int j;
		for (int i = 0; i < n; i++) begin
			x = m_win[a][i];
			j = i;
			while (j > 0 && t[j-1] > x) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = x;
		end
		return t[(n-1)/2];
	endfunction

	function automatic gyro_res_t rate_predict(input logic signed [15:0] raw[3]);
		longint mult, p, s;
		logic signed [27:0] v[3];
		logic signed [27:0] lim;
		logic ok, still;
		gyro_res_t r;
		mult = (m_range == 2'd0) ? 64'd10494585 : (m_range == 2'd1) ? 64'd20989170 :
			64'd83956679;
		still = 1'b0;
		for (int a = 0; a < 3; a++) begin
			p = longint'(raw[a]) * mult;
			s = (p + 64'sd32768) >>> 16;
			v[a] = sat_rate(s - longint'(m_bias[a]));
		end
		if (!m_cal) begin
			if (v[0] >= Q_ONE || v[0] <= -Q_ONE || v[1] >= Q_ONE || v[1] <= -Q_ONE ||
					v[2] >= Q_ONE || v[2] <= -Q_ONE) begin
				restart_collect();
			end else if (m_stable < STABLE_SAMPLES_DEF) begin
				ok = 1'b1;
				for (int a = 0; a < 3; a++) begin
					if (v[a] < m_min[a]) m_min[a] = v[a];
					if (v[a] > m_max[a]) m_max[a] = v[a];
					if (int'(m_max[a]) - int'(m_min[a]) > int'(SPREAD_MAX)) ok = 1'b0;
				end
				if (ok) m_stable++;
				else restart_collect();
			end else begin
				for (int a = 0; a < 3; a++)
					m_bias[a] = (int'(m_max[a]) + int'(m_min[a])) >>> 1;
				m_cal = 1'b1;
			end
		end
		if (m_warm >= WARMUP_SAMPLES_DEF) begin
			lim = m_cal ? STILL_CAL : STILL_UNCAL;
			if (m_fill < WINDOW_DEPTH_DEF) m_fill++;
			for (int a = 0; a < 3; a++) begin
				m_win[a][m_idx] = v[a];
				v[a] = axis_median(a, m_fill);
			end
			m_idx = (m_idx + 1 >= WINDOW_DEPTH_DEF) ? 0 : m_idx + 1;
			if (v[0] < lim && v[0] > -lim && v[1] < lim && v[1] > -lim &&
					v[2] < lim && v[2] > -lim) begin
				still = 1'b1;
				v[0] = '0; v[1] = '0; v[2] = '0;
			end
		end else begin
			m_warm++;
		end
		r.rx = v[0]; r.ry = v[1]; r.rz = v[2];
		r.cal = m_cal; r.still = still;
		r.bx = m_bias[0]; r.by = m_bias[1]; r.bz = m_bias[2];
		return r;
	endfunction

	function automatic logic idle_roll();
		return idle_free == 0 && $urandom_range(99) < 26;
	endfunction

	task automatic cfg_write(input cfg_reg_t idx, input logic [27:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_RANGE:   m_range = data[1:0];
			REG_PRELOAD: if (data[0]) begin
				m_cal = 1'b1;
				for (int a = 0; a < 3; a++) m_bias[a] = m_preset[a];
			end
			REG_PRESET_X: m_preset[0] = data;
			REG_PRESET_Y: m_preset[1] = data;
			REG_PRESET_Z: m_preset[2] = data;
			default: ;
		endcase
	endtask

	task automatic cfg_unknown(input logic [2:0] idx, input logic [27:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic send_beat(input logic signed [15:0] x, y, z, input logic typed,
			input gyro_res_t typed_res);
		logic signed [15:0] raw[3];
		gyro_res_t r;
		while (idle_roll()) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.raw_x <= x;
		sample.raw_y <= y;
		sample.raw_z <= z;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		raw[0] = x; raw[1] = y; raw[2] = z;
		r = rate_predict(raw);
		rate_expect_q.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (rate_expect_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic field_check(input string name, input logic [27:0] e, a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		gyro_res_t e;
		if (arst_n && result.valid && result.ready) begin
			if (rate_expect_q.size() == 0) begin
				$display("%0t unexpected result beat: expected none actual %0h", $time,
					result.rate_x);
				errors++;
			end else begin
				e = rate_expect_q.pop_front();
				field_check("rate_x", e.rx, result.rate_x);
				field_check("rate_y", e.ry, result.rate_y);
				field_check("rate_z", e.rz, result.rate_z);
				field_check("is_calibrated", e.cal, result.is_calibrated);
				field_check("held_still", e.still, result.held_still);
				field_check("bias_out_x", e.bx, result.bias_out_x);
				field_check("bias_out_y", e.by, result.bias_out_y);
				field_check("bias_out_z", e.bz, result.bias_out_z);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result.ready <= 1'b0;
		else
			result.ready <= !idle_roll();
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("gyro_bias_calibrate_median_filter regression: fail");
			$finish;
		end
	end

	stim_row_t directed[20];
	gyro_res_t zero_res;

	initial begin
		logic signed [15:0] off[3];
		logic signed [15:0] s[3];
		int pick, n;
		sample.valid = 1'b0;
		sample.raw_x = '0;
		sample.raw_y = '0;
		sample.raw_z = '0;
		result.ready = 1'b0;
		m_range = '0;
		for (int a = 0; a < 3; a++) m_preset[a] = '0;
		restart_collect();
		m_cal = 1'b0; m_warm = 0; m_fill = 0; m_idx = 0;
		zero_res = '0;
		directed = '{
			'{16'sd0, 16'sd0, 16'sd0, 1'b1},
			'{16'sd0, 16'sd0, 16'sd0, 1'b1},
			'{16'sd1, -16'sd1, 16'sd0, 1'b0},
			'{16'sd32767, 16'sd0, 16'sd0, 1'b0},
			'{-16'sd32768, 16'sd0, 16'sd0, 1'b0},
			'{16'sd0, 16'sd32767, -16'sd32768, 1'b0},
			'{16'sd0, 16'sd0, 16'sd0, 1'b0},
			'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0},
			'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
			'{16'sd40, -16'sd40, 16'sd5, 1'b0},
			'{16'sd400, 16'sd0, 16'sd0, 1'b0},
			'{16'sd0, 16'sd0, 16'sd0, 1'b0},
			'{16'sd6000, 16'sd0, 16'sd0, 1'b0},
			'{16'sd6000, 16'sd0, 16'sd0, 1'b0},
			'{16'sd6000, 16'sd0, 16'sd0, 1'b0},
			'{16'sd2, 16'sd3, 16'sd1, 1'b0},
			'{-16'sd2, 16'sd1, 16'sd0, 1'b0},
			'{16'sd0, 16'sd0, -16'sd1, 1'b0},
			'{16'sd1, 16'sd0, 16'sd0, 1'b0},
			'{16'sd0, 16'sd1, 16'sd2, 1'b0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_beat(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
				zero_res);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			cfg_write(REG_RANGE, 28'(ph % 4));
			case (ph)
				3: begin
					cfg_write(REG_PRESET_X, 28'h8000000);
					cfg_write(REG_PRESET_Y, 28'h7FFFFFF);
					cfg_write(REG_PRESET_Z, 28'h0000000);
				end
				6: begin
					cfg_write(REG_PRESET_X, 28'h7FFFFFF);
					cfg_write(REG_PRESET_Y, 28'h8000000);
					cfg_write(REG_PRESET_Z, 28'h7FFFFFF);
				end
				default: begin
					cfg_write(REG_PRESET_X, 28'($urandom));
					cfg_write(REG_PRESET_Y, 28'($signed(28'($urandom_range(200000))) - 100000));
					cfg_write(REG_PRESET_Z, 28'($urandom));
				end
			endcase
			cfg_write(REG_PRELOAD, (ph % 3 == 1) ? 28'd1 : 28'd0);
			cfg_unknown(3'd5 + 3'(ph % 3), 28'($urandom));
			cfg_we <= 1'b0;
			@(posedge clk);
			for (int a = 0; a < 3; a++) off[a] = 16'($signed(11'($urandom)));
			n = 200;
			for (int i = 0; i < n; i++) begin
				idle_free = (ph == 4 && i >= 50 && i < 150) ? 1 : 0;
				pick = $urandom_range(99);
				for (int a = 0; a < 3; a++) begin
					if (pick < 6)
						s[a] = 16'($urandom);
					else if (pick < 9)
						s[a] = off[a] + 16'sd600;
					else
						s[a] = off[a] + 16'($signed(5'($urandom)));
				end
				send_beat(s[0], s[1], s[2], 1'b0, zero_res);
			end
			idle_free = 0;
			drain();
		end

		if (errors == 0)
			$display("gyro_bias_calibrate_median_filter regression: pass");
		else
			$display("gyro_bias_calibrate_median_filter regression: fail");
		$finish;
	end
endmodule
